FILE: design/avph_pkg.sv
// ----------------------------------------------------------------------------
// avph_pkg
// shared widths and codes of the absolute value priority heap
// ----------------------------------------------------------------------------
package avph_pkg;

    localparam int HeapCapacity = 1024;
    localparam int ValueWidth   = 32;
    localparam int MagWidth     = ValueWidth - 1;
    localparam int AddrWidth    = $clog2(HeapCapacity);
    localparam int CountWidth   = $clog2(HeapCapacity + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSH_OK  = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

FILE: design/absolute_value_priority_heap.sv
// ----------------------------------------------------------------------------
// absolute_value_priority_heap
// two min-heaps of magnitudes in block memories, ordered by absolute value
// ----------------------------------------------------------------------------
// Input words on s_axis carry cmd (push or pop) and a signed value. Each
// input word makes exactly one output word on m_axis with a status and,
// for a pop, the removed value. Positive values live in one heap, zero and
// negative values as magnitudes in the other; a pop serves the smaller root,
// the negative side on a tie.
// One word is handled at a time. A push sifts up level by level (read
// parent, then compare and write); a pop reads both roots, then the last
// entry, and sifts down level by level (read two children, then compare
// and write). A push into a full heap ends without a sift; otherwise how
// long a word takes is set by how far it climbs or sinks and by the single
// read port of each heap memory.
// A result waits in a pending register until the output register is free.
// While the receiver stalls the next word is still taken; the block stalls
// only when its result is ready and the output register is still full.
// Reset clears the counts and control; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module absolute_value_priority_heap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] popped_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int VW = avph_pkg::ValueWidth;
    localparam int MW = avph_pkg::MagWidth;
    localparam int AW = avph_pkg::AddrWidth;
    localparam int CW = avph_pkg::CountWidth;

    typedef enum logic [3:0] {
        S_IDLE, S_ROOTS, S_PICK, S_DN_LOAD, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_WAIT, S_DN_CMP, S_DONE
    } state_t;

    // heap memories, index = heap slot - 1
    logic [MW-1:0] pos_mem [avph_pkg::HeapCapacity];
    logic [MW-1:0] neg_mem [avph_pkg::HeapCapacity];

    // one read and one write port per memory, muxed by the side in work
    logic          rd_en, wr_en, rd_side, wr_side;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [MW-1:0] wr_data;
    logic [MW-1:0] pos_q, neg_q;

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_side)
        begin
            pos_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_side)
        begin
            neg_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            pos_q <= pos_mem[rd_addr];
            neg_q <= neg_mem[rd_addr];
        end
    end

    wire [MW-1:0] rd_q = rd_side ? neg_q : pos_q;

    state_t        state_reg;
    logic [CW-1:0] pos_cnt_reg, neg_cnt_reg;
    logic          side_reg;          // 1 = negative heap
    logic [MW-1:0] key_reg;           // entry being sifted
    logic [CW-1:0] idx_reg;           // current 1-based slot
    logic [CW-1:0] lim_reg;           // count during sift down
    logic [MW-1:0] lc_reg;            // left child value
    logic [MW-1:0] top_reg;           // removed root
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [VW-1:0] out_value_reg;
    logic          res_pend_reg;
    logic [1:0]    res_status_reg;
    logic [VW-1:0] res_value_reg;

    // input decode
    wire [VW-1:0] in_v    = s_axis_tdata[VW-1:0];
    wire          in_sign = in_v[VW-1];
    wire [VW-1:0] in_neg  = ~in_v + VW'(1);
    wire [MW-1:0] in_mag  = in_sign ? ((in_neg[VW-1]) ? {MW{1'b1}} : in_neg[MW-1:0])
                                    : in_v[MW-1:0];
    wire          in_side = in_sign || (in_v == '0);

    assign s_axis_tready = (state_reg == S_IDLE) && !res_pend_reg;
    wire in_acc = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    wire [CW-1:0] parent   = idx_reg >> 1;
    wire [CW:0]   child_l  = {idx_reg, 1'b0};
    wire [CW:0]   lim_ext  = {1'b0, lim_reg};

    always_comb
    begin
        rd_en   = 1'b0;
        rd_side = side_reg;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_side = side_reg;
        wr_addr = '0;
        wr_data = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_axis_tuser == avph_pkg::CMD_POP)
                begin
                    rd_en = 1'b1;           // both roots at slot 1
                end
            end
            S_PICK:
            begin
                // read the last entry of the chosen side
                rd_en   = 1'b1;
                rd_side = (neg_cnt_reg != '0) &&
                          ((pos_cnt_reg == '0) || (pos_q >= neg_q));
                rd_addr = AW'(((rd_side ? neg_cnt_reg : pos_cnt_reg)) - CW'(1));
            end
            S_UP_RD:
            begin
                if (idx_reg > CW'(1))
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(parent - CW'(1));
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - CW'(1));
                end
            end
            S_UP_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg - CW'(1));
                wr_data = (rd_q > key_reg) ? rd_q : key_reg;
            end
            S_DN_RD:
            begin
                if (child_l <= lim_ext)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(child_l - (CW+1)'(1));
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - CW'(1));
                end
            end
            S_DN_WAIT:
            begin
                if (child_l + (CW+1)'(1) <= lim_ext)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(child_l);
                end
            end
            S_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg - CW'(1));
                if (child_l + (CW+1)'(1) <= lim_ext && rd_q <= lc_reg)
                begin
                    wr_data = (key_reg <= rd_q) ? key_reg : rd_q;
                end
                else
                begin
                    wr_data = (key_reg <= lc_reg) ? key_reg : lc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_cnt_reg    <= '0;
            neg_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            res_pend_reg   <= 1'b0;
            side_reg       <= 1'b0;
            key_reg        <= '0;
            idx_reg        <= '0;
            lim_reg        <= '0;
            lc_reg         <= '0;
            top_reg        <= '0;
            out_status_reg <= '0;
            out_value_reg  <= '0;
            res_status_reg <= '0;
            res_value_reg  <= '0;
        end
        else
        begin
            // output register hands over a finished result
            if (res_pend_reg && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_value_reg  <= res_value_reg;
                res_pend_reg   <= 1'b0;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser == avph_pkg::CMD_POP)
                        begin
                            state_reg <= S_ROOTS;
                        end
                        else if ((in_side ? neg_cnt_reg : pos_cnt_reg) ==
                                 CW'(avph_pkg::HeapCapacity))
                        begin
                            res_pend_reg   <= 1'b1;
                            res_status_reg <= avph_pkg::ST_FULL;
                            res_value_reg  <= '0;
                        end
                        else
                        begin
                            side_reg <= in_side;
                            key_reg  <= in_mag;
                            if (in_side)
                            begin
                                idx_reg     <= neg_cnt_reg + CW'(1);
                                neg_cnt_reg <= neg_cnt_reg + CW'(1);
                            end
                            else
                            begin
                                idx_reg     <= pos_cnt_reg + CW'(1);
                                pos_cnt_reg <= pos_cnt_reg + CW'(1);
                            end
                            state_reg <= S_UP_RD;
                        end
                    end
                end
                S_ROOTS:
                begin
                    if (pos_cnt_reg == '0 && neg_cnt_reg == '0)
                    begin
                        res_pend_reg   <= 1'b1;
                        res_status_reg <= avph_pkg::ST_EMPTY;
                        res_value_reg  <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    side_reg <= rd_side;
                    top_reg  <= rd_side ? neg_q : pos_q;
                    idx_reg  <= CW'(1);
                    if (rd_side)
                    begin
                        lim_reg     <= neg_cnt_reg - CW'(1);
                        neg_cnt_reg <= neg_cnt_reg - CW'(1);
                    end
                    else
                    begin
                        lim_reg     <= pos_cnt_reg - CW'(1);
                        pos_cnt_reg <= pos_cnt_reg - CW'(1);
                    end
                    state_reg <= S_DN_LOAD;
                end
                S_DN_LOAD:
                begin
                    // the moved last entry becomes the sift key
                    key_reg   <= rd_q;
                    state_reg <= S_DN_RD;
                end
                S_UP_RD:
                begin
                    if (idx_reg > CW'(1))
                    begin
                        state_reg <= S_UP_CMP;
                    end
                    else
                    begin
                        res_pend_reg   <= 1'b1;
                        res_status_reg <= avph_pkg::ST_PUSH_OK;
                        res_value_reg  <= '0;
                        state_reg      <= S_DONE;
                    end
                end
                S_UP_CMP:
                begin
                    if (rd_q > key_reg)
                    begin
                        // parent moves down, keep climbing
                        idx_reg   <= parent;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        res_pend_reg   <= 1'b1;
                        res_status_reg <= avph_pkg::ST_PUSH_OK;
                        res_value_reg  <= '0;
                        state_reg      <= S_DONE;
                    end
                end
                S_DN_RD:
                begin
                    if (child_l <= lim_ext)
                    begin
                        state_reg <= S_DN_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                        res_pend_reg   <= 1'b1;
                        res_status_reg <= avph_pkg::ST_POPPED;
                        res_value_reg  <= side_reg ? (~{1'b0, top_reg} + VW'(1))
                                                   : {1'b0, top_reg};
                    end
                end
                S_DN_WAIT:
                begin
                    lc_reg    <= rd_q;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (child_l + (CW+1)'(1) <= lim_ext && rd_q <= lc_reg)
                    begin
                        if (key_reg <= rd_q)
                        begin
                            state_reg <= S_DN_RD;
                            lim_reg   <= '0;
                        end
                        else
                        begin
                            idx_reg   <= CW'(child_l + (CW+1)'(1));
                            state_reg <= S_DN_RD;
                        end
                    end
                    else
                    begin
                        if (key_reg <= lc_reg)
                        begin
                            state_reg <= S_DN_RD;
                            lim_reg   <= '0;
                        end
                        else
                        begin
                            idx_reg   <= CW'(child_l);
                            state_reg <= S_DN_RD;
                        end
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
